>>> design/wsdf_pkg.sv
// Package with the shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsdf_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_UNEXPECTED = 3'd1;
    localparam t_status ST_TOO_BIG    = 3'd2;
    localparam t_status ST_INCOMPLETE = 3'd3;
    localparam t_status ST_TRUNC_HDR  = 3'd4;

    localparam logic [7:0] RSV_MASK    = 8'h70;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] OP_TEXT_MAX = 4'd2;
    localparam logic [3:0] OP_CTRL_MIN = 4'd8;
    localparam logic [3:0] OP_CTRL_MAX = 4'd10;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_done;
        t_status     status;
        logic [3:0]  frame_opcode;
        logic        fin_flag;
        logic        masked_flag;
        logic [31:0] payload_length;
        logic [3:0]  header_length;
    } t_result;

endpackage

>>> design/wsdf_if.sv
// Stream interfaces for the deframer: received bytes in, results out.
`timescale 1ns / 1ps

interface wsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_last;

    modport source (output valid, output data_byte, output buffer_last, input ready);
    modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface wsdf_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       payload_byte;
    logic             byte_valid;
    logic             frame_done;
    logic [2:0]       status;
    logic [3:0]       frame_opcode;
    logic             fin_flag;
    logic             masked_flag;
    logic [31:0]      payload_length;
    logic [3:0]       header_length;

    modport source (
        output valid, output payload_byte, output byte_valid, output frame_done,
        output status, output frame_opcode, output fin_flag, output masked_flag,
        output payload_length, output header_length, input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_valid, input frame_done,
        input status, input frame_opcode, input fin_flag, input masked_flag,
        input payload_length, input header_length, output ready
    );
endinterface

>>> design/websocket_frame_deframer.sv
// A result appears in the output register in the cycle after its input beat is accepted.
// Throughput: one byte beat per cycle; the only stall is a full output register held by
// downstream, since all parsing is one pass of logic between the state and result registers.
// Beats that produce no result (most header bytes, trailing bytes) only update the state.
// Reset is synchronous and active low: the parser returns to the first header byte and
// the output register empties; no clearing pass is needed.
`timescale 1ns / 1ps

module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsdf_in_if.sink     i_in,
    wsdf_out_if.source  o_out
);

    logic              accept;
    logic              can_take;
    logic              res_valid;
    wsdf_pkg::t_result res;

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    wsdf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_in.data_byte),
        .i_buffer_last (i_in.buffer_last),
        .o_res         (res),
        .o_res_valid   (res_valid)
    );

    wsdf_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res_valid),
        .i_res      (res),
        .o_can_take (can_take),
        .o_out      (o_out)
    );

    // Every result carries a payload byte, a frame status, or both.
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.byte_valid || o_out.frame_done))
        else $error("result with neither payload byte nor status");

    // Status fields stay zero unless the result ends the frame.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.frame_done) |->
            (o_out.status == wsdf_pkg::ST_OK && o_out.payload_length == 32'd0 &&
             o_out.header_length == 4'd0))
        else $error("status fields set on a payload-only result");

    // An oversize frame reports no lengths.
    a_too_big_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done && o_out.status == wsdf_pkg::ST_TOO_BIG) |->
            (o_out.payload_length == 32'd0 && o_out.header_length == 4'd0 &&
             !o_out.byte_valid))
        else $error("too-big status with lengths or payload");

    // A truncated header never comes with a payload byte or a payload length.
    a_trunc_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done && o_out.status == wsdf_pkg::ST_TRUNC_HDR) |->
            (!o_out.byte_valid && o_out.payload_length == 32'd0))
        else $error("truncated header status with payload");

    // An accepted beat that produces a result makes the output valid next cycle.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_valid) |=> o_out.valid)
        else $error("result lost in output register");

endmodule

>>> design/wsdf_parser.sv
// Header parser, key capture and payload unmasking for one frame per buffer.
`timescale 1ns / 1ps

module wsdf_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_buffer_last,
    output wsdf_pkg::t_result  o_res,
    output logic               o_res_valid
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT,
        PH_KEY,
        PH_PAYLOAD,
        PH_IGNORE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hidx, n_hidx;
    logic [15:0] r_fhb, n_fhb;
    logic [31:0] r_len, n_len;
    logic        r_hinz, n_hinz;
    logic [31:0] r_key, n_key;
    logic [31:0] r_pcnt, n_pcnt;
    logic        r_pend, n_pend;

    logic [3:0]  op;
    logic [6:0]  len7;
    logic        masked;
    logic [3:0]  ext_end;
    logic [3:0]  hdr_total;
    logic [31:0] pcnt_inc;
    logic [7:0]  key_byte;
    wsdf_pkg::t_status pend_status;

    function automatic wsdf_pkg::t_result put_status(
        input logic [15:0]       fhb,
        input wsdf_pkg::t_status st,
        input logic [31:0]       plen,
        input logic [3:0]        hlen
    );
        wsdf_pkg::t_result r;
        r                = '0;
        r.frame_done     = 1'b1;
        r.status         = st;
        r.frame_opcode   = fhb[11:8];
        r.fin_flag       = fhb[15];
        r.masked_flag    = fhb[7];
        r.payload_length = plen;
        r.header_length  = hlen;
        return r;
    endfunction

    assign op          = i_data_byte[3:0];
    assign len7        = n_fhb[6:0];
    assign masked      = n_fhb[7];
    assign ext_end     = (len7 == wsdf_pkg::LEN_EXT16) ? 4'd4 :
                         (len7 == wsdf_pkg::LEN_EXT64) ? 4'd10 : 4'd2;
    assign hdr_total   = ext_end + (masked ? 4'd4 : 4'd0);
    assign pcnt_inc    = r_pcnt + 32'd1;
    assign pend_status = r_pend ? wsdf_pkg::ST_UNEXPECTED : wsdf_pkg::ST_OK;

    always_comb begin
        case (r_pcnt[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        if (!r_fhb[7]) begin
            key_byte = 8'h00;
        end
    end

    // Header fields first, so that the end-of-header checks see this beat's byte.
    always_comb begin
        n_fhb  = r_fhb;
        n_hidx = r_hidx;
        n_len  = r_len;
        n_hinz = r_hinz;
        n_key  = r_key;
        n_pend = r_pend;
        if (i_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    n_fhb  = {i_data_byte, 8'h00};
                    n_hidx = 4'd1;
                    n_len  = '0;
                    n_hinz = 1'b0;
                    n_key  = '0;
                    n_pend = !((op <= wsdf_pkg::OP_TEXT_MAX) ||
                               (op >= wsdf_pkg::OP_CTRL_MIN && op <= wsdf_pkg::OP_CTRL_MAX));
                end
                PH_SECOND: begin
                    n_fhb  = {r_fhb[15:8], i_data_byte};
                    n_hidx = 4'd2;
                    n_len  = (i_data_byte[6:0] < wsdf_pkg::LEN_EXT16) ?
                             {25'd0, i_data_byte[6:0]} : '0;
                end
                PH_EXT: begin
                    // The upper four bytes of a 64-bit length only need to be zero.
                    if (r_fhb[6:0] == wsdf_pkg::LEN_EXT64 && r_hidx < 4'd6) begin
                        n_hinz = r_hinz | (i_data_byte != 8'h00);
                    end else begin
                        n_len = {r_len[23:0], i_data_byte};
                    end
                    n_hidx = r_hidx + 4'd1;
                end
                PH_KEY: begin
                    n_key  = {r_key[23:0], i_data_byte};
                    n_hidx = r_hidx + 4'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pcnt      = r_pcnt;
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    n_pcnt = '0;
                    if (i_buffer_last) begin
                        o_res_valid      = 1'b1;
                        o_res.frame_done = 1'b1;
                        o_res.status     = wsdf_pkg::ST_UNEXPECTED;
                    end else if ((i_data_byte & wsdf_pkg::RSV_MASK) != 8'h00) begin
                        o_res_valid = 1'b1;
                        o_res       = put_status(n_fhb, wsdf_pkg::ST_UNEXPECTED, '0, '0);
                        n_phase     = PH_IGNORE;
                    end else begin
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND, PH_EXT, PH_KEY: begin
                    if (len7 == wsdf_pkg::LEN_EXT64 && n_hidx == 4'd10 && n_hinz) begin
                        o_res_valid = 1'b1;
                        o_res       = put_status(n_fhb, wsdf_pkg::ST_TOO_BIG, '0, '0);
                        n_phase     = PH_IGNORE;
                    end else if (n_hidx < ext_end || n_hidx < hdr_total) begin
                        n_phase = (n_hidx < ext_end) ? PH_EXT : PH_KEY;
                        if (i_buffer_last) begin
                            o_res_valid = 1'b1;
                            o_res = put_status(n_fhb, wsdf_pkg::ST_TRUNC_HDR, '0, n_hidx);
                        end
                    end else begin
                        n_pcnt = '0;
                        if (n_len == 32'd0) begin
                            o_res_valid = 1'b1;
                            o_res       = put_status(n_fhb, pend_status, '0, hdr_total);
                            n_phase     = PH_IGNORE;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            if (i_buffer_last) begin
                                o_res_valid = 1'b1;
                                o_res = put_status(n_fhb, wsdf_pkg::ST_INCOMPLETE,
                                                   n_len, hdr_total);
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pcnt = pcnt_inc;
                    if (pcnt_inc == r_len) begin
                        o_res   = put_status(n_fhb, pend_status, r_len, hdr_total);
                        n_phase = PH_IGNORE;
                    end else if (i_buffer_last) begin
                        o_res = put_status(n_fhb, wsdf_pkg::ST_INCOMPLETE, r_len, hdr_total);
                    end
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_data_byte ^ key_byte;
                    o_res.byte_valid   = 1'b1;
                end
                default: begin
                end
            endcase
            if (i_buffer_last) begin
                n_phase = PH_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_hidx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= (i_accept && i_buffer_last) ? 4'd0 : n_hidx;
        end
        r_fhb  <= n_fhb;
        r_len  <= n_len;
        r_hinz <= n_hinz;
        r_key  <= n_key;
        r_pcnt <= n_pcnt;
        r_pend <= n_pend;
    end

endmodule

>>> design/wsdf_out_stage.sv
// Result register that drives the output stream and tells upstream when a beat fits.
`timescale 1ns / 1ps

module wsdf_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsdf_pkg::t_result i_res,
    output logic              o_can_take,
    wsdf_out_if.source        o_out
);

    logic              r_valid;
    wsdf_pkg::t_result r_res;

    // A new beat may enter when the register is empty or its held result leaves in this same cycle.
    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.payload_byte   = r_res.payload_byte;
    assign o_out.byte_valid     = r_res.byte_valid;
    assign o_out.frame_done     = r_res.frame_done;
    assign o_out.status         = r_res.status;
    assign o_out.frame_opcode   = r_res.frame_opcode;
    assign o_out.fin_flag       = r_res.fin_flag;
    assign o_out.masked_flag    = r_res.masked_flag;
    assign o_out.payload_length = r_res.payload_length;
    assign o_out.header_length  = r_res.header_length;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the WebSocket frame deframer, with a scoreboard class.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 200;
    localparam int HOLD_CYCLES  = 150;

    typedef logic [7:0] t_byte_q[$];

    typedef enum logic [2:0] {
        DF_HDR0, DF_HDR1, DF_EXTLEN, DF_KEY, DF_BODY, DF_SKIP
    } t_deframe_phase;

    typedef enum int { FORM_SHORT, FORM_EXT16, FORM_EXT64 } t_len_form;

    class frame_scoreboard;
        t_deframe_phase      phase;
        int                  hdr_count;
        logic [15:0]         hdr_bits;
        logic [31:0]         len_acc;
        bit                  len_hi_set;
        logic [31:0]         mkey;
        logic [31:0]         body_count;
        wsdf_pkg::t_status   op_status;
        wsdf_pkg::t_result   frame_results_q[$];
        int                  errors;

        function void clear_state();
            phase      = DF_HDR0;
            hdr_count  = 0;
            hdr_bits   = '0;
            len_acc    = '0;
            len_hi_set = 1'b0;
            mkey       = '0;
            body_count = '0;
            op_status  = wsdf_pkg::ST_OK;
        endfunction

        function int ext_bytes();
            if (hdr_bits[6:0] == wsdf_pkg::LEN_EXT16) return 2;
            if (hdr_bits[6:0] == wsdf_pkg::LEN_EXT64) return 8;
            return 0;
        endfunction

        function int header_bytes();
            return 2 + ext_bytes() + (hdr_bits[7] ? 4 : 0);
        endfunction

        function wsdf_pkg::t_result with_status(wsdf_pkg::t_result r, wsdf_pkg::t_status st,
                                                logic [31:0] plen, int hlen);
            r.frame_done     = 1'b1;
            r.status         = st;
            r.frame_opcode   = hdr_bits[11:8];
            r.fin_flag       = hdr_bits[15];
            r.masked_flag    = hdr_bits[7];
            r.payload_length = plen;
            r.header_length  = 4'(hlen);
            return r;
        endfunction

        // Decides what follows a header byte once the second one has been seen.
        function bit header_step(bit last, inout wsdf_pkg::t_result r);
            int ext;
            int total;
            ext   = ext_bytes();
            total = header_bytes();
            if (hdr_bits[6:0] == wsdf_pkg::LEN_EXT64 && hdr_count == 10 && len_hi_set) begin
                r     = with_status(r, wsdf_pkg::ST_TOO_BIG, '0, 0);
                phase = DF_SKIP;
                return 1'b1;
            end
            if (hdr_count < 2 + ext || hdr_count < total) begin
                phase = (hdr_count < 2 + ext) ? DF_EXTLEN : DF_KEY;
                if (last) begin
                    r = with_status(r, wsdf_pkg::ST_TRUNC_HDR, '0, hdr_count);
                    return 1'b1;
                end
                return 1'b0;
            end
            body_count = '0;
            if (len_acc == 0) begin
                r     = with_status(r, op_status, '0, total);
                phase = DF_SKIP;
                return 1'b1;
            end
            phase = DF_BODY;
            if (last) begin
                r = with_status(r, wsdf_pkg::ST_INCOMPLETE, len_acc, total);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            wsdf_pkg::t_result r;
            bit                emit;
            logic [3:0]        op;
            int                k;
            logic [7:0]        kb;
            r    = '0;
            emit = 1'b0;
            case (phase)
                DF_HDR0: begin
                    op         = b[3:0];
                    hdr_bits   = {b, 8'h00};
                    hdr_count  = 1;
                    len_acc    = '0;
                    len_hi_set = 1'b0;
                    mkey       = '0;
                    body_count = '0;
                    op_status  = (op <= wsdf_pkg::OP_TEXT_MAX ||
                                  (op >= wsdf_pkg::OP_CTRL_MIN && op <= wsdf_pkg::OP_CTRL_MAX))
                                 ? wsdf_pkg::ST_OK : wsdf_pkg::ST_UNEXPECTED;
                    if (last) begin
                        r.frame_done = 1'b1;
                        r.status     = wsdf_pkg::ST_UNEXPECTED;
                        emit         = 1'b1;
                    end else if ((b & wsdf_pkg::RSV_MASK) != 8'h00) begin
                        r     = with_status(r, wsdf_pkg::ST_UNEXPECTED, '0, 0);
                        phase = DF_SKIP;
                        emit  = 1'b1;
                    end else begin
                        phase = DF_HDR1;
                    end
                end
                DF_HDR1: begin
                    hdr_bits[7:0] = b;
                    hdr_count     = 2;
                    len_acc       = (hdr_bits[6:0] < wsdf_pkg::LEN_EXT16) ?
                                    32'(hdr_bits[6:0]) : '0;
                    emit          = header_step(last, r);
                end
                DF_EXTLEN: begin
                    // The upper four bytes of a 64-bit length only flag an oversize frame.
                    if (hdr_bits[6:0] == wsdf_pkg::LEN_EXT64 && hdr_count < 6) begin
                        if (b != 8'h00) len_hi_set = 1'b1;
                    end else begin
                        len_acc = {len_acc[23:0], b};
                    end
                    hdr_count = (hdr_count + 1) & 15;
                    emit      = header_step(last, r);
                end
                DF_KEY: begin
                    mkey      = {mkey[23:0], b};
                    hdr_count = (hdr_count + 1) & 15;
                    emit      = header_step(last, r);
                end
                DF_BODY: begin
                    k              = int'(body_count[1:0]);
                    kb             = hdr_bits[7] ? 8'(mkey >> (24 - 8 * k)) : 8'h00;
                    r.payload_byte = b ^ kb;
                    r.byte_valid   = 1'b1;
                    emit           = 1'b1;
                    body_count++;
                    if (body_count == len_acc) begin
                        r     = with_status(r, op_status, len_acc, header_bytes());
                        phase = DF_SKIP;
                    end else if (last) begin
                        r = with_status(r, wsdf_pkg::ST_INCOMPLETE, len_acc, header_bytes());
                    end
                end
                default: ;
            endcase
            if (last) begin
                phase     = DF_HDR0;
                hdr_count = 0;
            end
            if (emit) frame_results_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(wsdf_pkg::t_result got);
            wsdf_pkg::t_result want;
            if (frame_results_q.size() == 0) begin
                $error("result beat with no expected result pending");
                errors++;
                return;
            end
            want = frame_results_q.pop_front();
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("frame_opcode", 32'(want.frame_opcode), 32'(got.frame_opcode));
            compare_field("fin_flag", 32'(want.fin_flag), 32'(got.fin_flag));
            compare_field("masked_flag", 32'(want.masked_flag), 32'(got.masked_flag));
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("header_length", 32'(want.header_length), 32'(got.header_length));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsdf_in_if  in_if ();
    wsdf_out_if out_if ();

    websocket_frame_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    always #1 i_clk = ~i_clk;

    frame_scoreboard sb = new();
    int  bytes_sent  = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    bit  long_hold_done = 1'b0;
    logic [3:0] known_ops[6] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10};

    // Sender pacing: bursts of random length, separated by random gaps.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_byte(logic [7:0] b, bit last);
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.buffer_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_buffer(t_byte_q q);
        foreach (q[i]) begin
            pace();
            send_byte(q[i], i == q.size() - 1);
        end
    endtask

    function automatic t_byte_q make_frame(bit fin, logic [2:0] rsv, logic [3:0] op, bit masked,
                                           t_len_form form, logic [31:0] plen,
                                           logic [31:0] len_hi, logic [31:0] key, int body);
        t_byte_q q;
        q.push_back({fin, rsv, op});
        case (form)
            FORM_SHORT: q.push_back({masked, plen[6:0]});
            FORM_EXT16: begin
                q.push_back({masked, wsdf_pkg::LEN_EXT16});
                q.push_back(plen[15:8]);
                q.push_back(plen[7:0]);
            end
            default: begin
                q.push_back({masked, wsdf_pkg::LEN_EXT64});
                for (int i = 3; i >= 0; i--) q.push_back(8'(len_hi >> (8 * i)));
                for (int i = 3; i >= 0; i--) q.push_back(8'(plen >> (8 * i)));
            end
        endcase
        if (masked) for (int i = 3; i >= 0; i--) q.push_back(8'(key >> (8 * i)));
        repeat (body) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic t_byte_q cut_to(t_byte_q q, int n);
        while (q.size() > n) q.pop_back();
        return q;
    endfunction

    task automatic random_buffer();
        t_byte_q     q;
        int          pick;
        t_len_form   form;
        logic [31:0] plen;
        logic [31:0] hi;
        bit          masked;
        logic [3:0]  op;
        pick   = $urandom_range(0, 99);
        masked = 1'($urandom_range(0, 1));
        op     = ($urandom_range(0, 4) == 0) ? 4'($urandom) : known_ops[$urandom_range(0, 5)];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: form = FORM_SHORT;
            6, 7:             form = FORM_EXT16;
            default:          form = FORM_EXT64;
        endcase
        if (pick < 70) begin
            plen = $urandom_range(0, 20);
            q = make_frame(1'($urandom_range(0, 1)), 3'b000, op, masked, form, plen, '0,
                           $urandom, plen);
        end else if (pick < 80) begin
            // Buffer cut short somewhere in the header or the payload.
            plen = $urandom_range(1, 20);
            q = make_frame(1'($urandom_range(0, 1)), 3'b000, op, masked, form, plen, '0,
                           $urandom, plen);
            q = cut_to(q, $urandom_range(1, q.size() - 1));
        end else if (pick < 85) begin
            // Long announced length, so the buffer always ends before the payload is complete.
            if ($urandom_range(0, 1)) begin
                form = FORM_EXT16;
                plen = $urandom_range(21, 65535);
            end else begin
                form = FORM_EXT64;
                plen = $urandom | 32'h0000_0100;
            end
            q = make_frame(1'($urandom_range(0, 1)), 3'b000, op, masked, form, plen, '0,
                           $urandom, $urandom_range(0, 8));
        end else if (pick < 90) begin
            hi = $urandom;
            if (hi == 0) hi = 32'h1;
            q = make_frame(1'($urandom_range(0, 1)), 3'b000, op, masked, FORM_EXT64,
                           $urandom, hi, $urandom, $urandom_range(0, 3));
        end else if (pick < 95) begin
            plen = $urandom_range(0, 8);
            q = make_frame(1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), op, masked,
                           form, plen, '0, $urandom, plen);
        end else begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
        send_buffer(q);
    endtask

    // Receiver: stretches of steady readiness, random stalls, and one long hold-off.
    initial begin
        out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!long_hold_done && bytes_sent >= 150) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if ($urandom_range(0, 9) < 3) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(8, 16)) begin
                    out_if.ready <= ($urandom_range(0, 3) != 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        wsdf_pkg::t_result got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.payload_byte   = out_if.payload_byte;
                got.byte_valid     = out_if.byte_valid;
                got.frame_done     = out_if.frame_done;
                got.status         = out_if.status;
                got.frame_opcode   = out_if.frame_opcode;
                got.fin_flag       = out_if.fin_flag;
                got.masked_flag    = out_if.masked_flag;
                got.payload_length = out_if.payload_length;
                got.header_length  = out_if.header_length;
                sb.check_result(got);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_byte_q q;
        int      random_start;
        sb.clear_state();
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.data_byte   <= 8'h00;
        in_if.buffer_last <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed buffers.
        q = '{8'h81};
        send_buffer(q);
        q = make_frame(1'b1, 3'b111, 4'd2, 1'b1, FORM_SHORT, 3, '0, 32'h1234_5678, 3);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd1, 1'b0, FORM_SHORT, 2, '0, '0, 2);
        send_buffer(q);
        q = make_frame(1'b0, 3'b000, 4'd2, 1'b1, FORM_SHORT, 5, '0, 32'hFFFF_FFFF, 5);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd9, 1'b1, FORM_SHORT, 0, '0, '0, 0);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd8, 1'b0, FORM_SHORT, 0, '0, '0, 0);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd3, 1'b0, FORM_SHORT, 3, '0, '0, 3);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd15, 1'b1, FORM_SHORT, 4, '0, 32'hA53C_0FF0, 4);
        send_buffer(cut_to(q, q.size() - 2));
        q = make_frame(1'b1, 3'b000, 4'd10, 1'b1, FORM_EXT16, 4, '0, 32'h5AC3_F00F, 4);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd2, 1'b1, FORM_EXT64, 9, 32'h8000_0000,
                       32'h0102_0304, 2);
        send_buffer(q);
        q = make_frame(1'b0, 3'b000, 4'd0, 1'b0, FORM_EXT64, 2, '0, '0, 2);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd1, 1'b0, FORM_EXT16, 6, '0, '0, 6);
        send_buffer(cut_to(q, 3));
        q = make_frame(1'b1, 3'b000, 4'd1, 1'b1, FORM_SHORT, 6, '0, 32'hDEAD_BEEF, 6);
        send_buffer(cut_to(q, 4));
        send_buffer(cut_to(q, 6));
        q = make_frame(1'b1, 3'b000, 4'd2, 1'b0, FORM_SHORT, 125, '0, '0, 125);
        send_buffer(q);
        q = make_frame(1'b0, 3'b000, 4'd1, 1'b1, FORM_EXT64, 32'hFFFF_FFFF, '0,
                       32'h00FF_00FF, 3);
        send_buffer(q);
        q = make_frame(1'b1, 3'b000, 4'd2, 1'b0, FORM_EXT16, 32'h0000_FFFF, '0, '0, 1);
        send_buffer(q);

        // Random buffers, mostly well-formed frames with random content.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) random_buffer();
        in_if.valid <= 1'b0;

        while (sb.frame_results_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
design/wsdf_pkg.sv
design/wsdf_if.sv
design/wsdf_parser.sv
design/wsdf_out_stage.sv
design/websocket_frame_deframer.sv
verif/tb.sv
